// File: hdl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
package sem_pkg;

  localparam int PixW  = 8;
  localparam int PosW  = 12;
  localparam int CfgW  = 13;
  localparam int SumW  = 17;
  localparam int RootW = 9;

  localparam logic [0:0] RegImageWidth  = 1'b0;
  localparam logic [0:0] RegImageHeight = 1'b1;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  magnitude;
    logic [11:0] row;
    logic [11:0] column;
    logic        last;
  } out_item_t;

  // Side information that rides along the root chain with each sum.
  typedef struct packed {
    logic        valid;
    logic        clip;
    logic [11:0] row;
    logic [11:0] column;
    logic        last;
  } tag_t;

endpackage

// File: hdl/sem_root_cell.sv
// One cell of the square root chain: settles one result bit per cycle.
module sem_root_cell #(
  parameter int Step = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sem_pkg::SumW-1:0]     rem_in,
  input  logic [sem_pkg::RootW-1:0]    root_in,
  input  sem_pkg::tag_t                tag_in,
  output logic [sem_pkg::SumW-1:0]     rem_out,
  output logic [sem_pkg::RootW-1:0]    root_out,
  output sem_pkg::tag_t                tag_out
);

  // Trial value (2*root + 2^Step) << Step against the remainder, where root
  // holds the bits above Step at their true weight.
  logic [sem_pkg::SumW+1:0] trial;
  logic [sem_pkg::RootW-1:0] root_try;

  always_comb begin
    root_try = root_in | (sem_pkg::RootW'(1) << Step);
    trial = (sem_pkg::SumW+2)'({root_in, 1'b0} | ((sem_pkg::RootW+1)'(1) << Step)) << Step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag_in.valid;
    end
    tag_out.clip   <= tag_in.clip;
    tag_out.row    <= tag_in.row;
    tag_out.column <= tag_in.column;
    tag_out.last   <= tag_in.last;
    if ({2'b00, rem_in} >= trial) begin
      rem_out  <= rem_in - sem_pkg::SumW'(trial);
      root_out <= root_try;
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in;
    end
  end

endmodule

// File: hdl/sobel_edge_magnitude.sv
// Top level of the Sobel 3x3 gradient magnitude block.
//
// Channel  Direction  Payload     Handshake
// in       input      in_item_t   in_valid / in_stall
// out      output     out_item_t  out_valid / out_stall
// cfg      input      13 bits     cfg_write, cfg_index
//
// The block takes one pixel item per clock while the output is not stalled.
// Each item passes a line store read stage, a window stage, a gradient stage,
// a squares stage and then a chain of nine root cells, one per result bit,
// then an output register. Reset clears positions, the window and the valid
// bits; the line stores hold nothing until written.
// A stall of a valid output freezes the whole pipeline and raises in_stall.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sem_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sem_pkg::out_item_t   out_item,
  input  logic                 cfg_write,
  input  logic [0:0]           cfg_index,
  input  logic [12:0]          cfg_data
);

  localparam int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CntW  = $clog2(MAX_WIDTH + 1) > 13 ? $clog2(MAX_WIDTH + 1) : 13;
  localparam int NCell = sem_pkg::RootW;

  logic [12:0] image_width;
  logic [12:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd4096;
      image_height <= 13'd4096;
    end else if (cfg_write) begin
      case (cfg_index)
        sem_pkg::RegImageWidth:  image_width  <= cfg_data;
        sem_pkg::RegImageHeight: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together; a full output register that is
  // stalled holds everything in place.
  logic adv;
  logic go;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign go       = in_valid && adv;

  // Effective dimensions, saturated to legal ranges.
  logic [CntW-1:0] w_eff;
  logic [12:0]     h_eff;
  always_comb begin
    if (CntW'(image_width) < CntW'(3))          w_eff = CntW'(3);
    else if (CntW'(image_width) > CntW'(MAX_WIDTH)) w_eff = CntW'(MAX_WIDTH);
    else                                         w_eff = CntW'(image_width);
    if (image_height < 13'd3)         h_eff = 13'd3;
    else if (image_height > 13'd4096) h_eff = 13'd4096;
    else                              h_eff = image_height;
  end

  // Position of the next pixel after frame start and wrap handling.
  logic [CntW-1:0] column_count;
  logic [12:0]     row_count;
  logic [CntW-1:0] c_cur;
  logic [12:0]     r_cur;
  always_comb begin
    c_cur = in_item.frame_start ? '0 : column_count;
    r_cur = in_item.frame_start ? '0 : row_count;
    if (c_cur >= w_eff) begin
      c_cur = '0;
      r_cur = r_cur + 13'd1;
    end
    if (r_cur >= h_eff) r_cur = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (go) begin
      column_count <= c_cur + CntW'(1);
      row_count    <= r_cur;
    end
  end

  // Line stores: the middle store reads the old entry and writes the new one in the same cycle.
  logic [7:0] store_upper [MAX_WIDTH];
  logic [7:0] store_middle [MAX_WIDTH];
  logic [7:0] up_q, mid_q, px_q;
  logic       s1_valid, s1_out, s1_last;
  logic [11:0] s1_row, s1_col;
  logic [AddrW-1:0] addr;
  assign addr = c_cur[AddrW-1:0];

  // Reads take the prior contents; the upper store's write uses the middle
  // store's current word, which needs a bypass across same-address writes
  // only through the registered read below.
  logic [7:0] mid_rd;
  always_ff @(posedge clk) begin
    if (go) begin
      up_q  <= store_upper[addr];
      mid_q <= store_middle[addr];
      store_middle[addr] <= in_item.pixel;
    end
  end
  assign mid_rd = mid_q;

  // The upper store takes the middle word in the following cycle, once it is read.
  logic [AddrW-1:0] addr_q;
  logic             wr_up;
  always_ff @(posedge clk) begin
    if (wr_up) store_upper[addr_q] <= mid_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_up    <= 1'b0;
    end else if (adv) begin
      s1_valid <= go;
      wr_up    <= go;
    end else begin
      wr_up    <= 1'b0;
    end
    if (go) begin
      px_q    <= in_item.pixel;
      addr_q  <= addr;
      s1_out  <= (r_cur >= 13'd2) && (c_cur >= CntW'(2));
      s1_row  <= 12'(r_cur - 13'd1);
      s1_col  <= 12'(c_cur - CntW'(1));
      s1_last <= (r_cur == h_eff - 13'd1) && (c_cur == w_eff - CntW'(1));
    end
  end

  // A read at an address written by the previous item must see that write.
  logic [7:0] up_fw, mid_fw;
  logic       same_q;
  logic [7:0] px_prev, mid_prev;
  always_ff @(posedge clk) begin
    if (rst) same_q <= 1'b0;
    else if (adv) same_q <= go && s1_valid && (addr == addr_q);
    if (adv && s1_valid) begin
      px_prev  <= px_q;
      mid_prev <= mid_fw;
    end
  end
  assign mid_fw = same_q ? px_prev : mid_q;
  assign up_fw  = same_q ? mid_prev : up_q;

  // Window: three rows by three columns, shifted left each item.
  logic [7:0] win [3][3];
  logic       s2_valid, s2_out, s2_last;
  logic [11:0] s2_row, s2_col;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) win[k][j] <= '0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        for (int k = 0; k < 3; k++) begin
          win[k][0] <= win[k][1];
          win[k][1] <= win[k][2];
        end
        win[0][2] <= up_fw;
        win[1][2] <= mid_fw;
        win[2][2] <= px_q;
      end
    end
    if (adv) begin
      s2_out  <= s1_out;
      s2_row  <= s1_row;
      s2_col  <= s1_col;
      s2_last <= s1_last;
    end
  end

  // Gradients as absolute values.
  logic signed [11:0] gx, gy;
  logic [10:0] ax, ay;
  logic        s3_valid, s3_last;
  logic [11:0] s3_row, s3_col;
  always_comb begin
    gx = 12'(signed'({4'b0, win[0][2]})) - 12'(signed'({4'b0, win[0][0]}))
       + 12'(signed'({3'b0, win[1][2], 1'b0})) - 12'(signed'({3'b0, win[1][0], 1'b0}))
       + 12'(signed'({4'b0, win[2][2]})) - 12'(signed'({4'b0, win[2][0]}));
    gy = 12'(signed'({4'b0, win[0][0]})) + 12'(signed'({3'b0, win[0][1], 1'b0}))
       + 12'(signed'({4'b0, win[0][2]})) - 12'(signed'({4'b0, win[2][0]}))
       - 12'(signed'({3'b0, win[2][1], 1'b0})) - 12'(signed'({4'b0, win[2][2]}));
  end
  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (adv) s3_valid <= s2_valid && s2_out;
    if (adv) begin
      ax      <= 11'(gx < 0 ? -gx : gx);
      ay      <= 11'(gy < 0 ? -gy : gy);
      s3_row  <= s2_row;
      s3_col  <= s2_col;
      s3_last <= s2_last;
    end
  end

  // Sum of squares; anything at or above 65536 clips to 255.
  logic [22:0] sq;
  assign sq = 23'(ax * ax) + 23'(ay * ay);

  logic [sem_pkg::SumW-1:0]  rem  [NCell+1];
  logic [sem_pkg::RootW-1:0] root [NCell+1];
  sem_pkg::tag_t             tag  [NCell+1];

  always_ff @(posedge clk) begin
    if (rst) tag[0].valid <= 1'b0;
    else if (adv) tag[0].valid <= s3_valid;
    if (adv) begin
      tag[0].clip   <= sq >= 23'd65536;
      tag[0].row    <= s3_row;
      tag[0].column <= s3_col;
      tag[0].last   <= s3_last;
      rem[0]        <= sem_pkg::SumW'(sq);
      root[0]       <= '0;
    end
  end

  // The root cells hold during a stall through a gated enable path: a cell
  // output is only taken forward when the chain advances.
  for (genvar i = 0; i < NCell; i++) begin : g_cell
    logic [sem_pkg::SumW-1:0]  r_o;
    logic [sem_pkg::RootW-1:0] q_o;
    sem_pkg::tag_t             t_o;
    sem_root_cell #(.Step(NCell - 1 - i)) u_cell (
      .clk, .rst,
      .rem_in(adv ? rem[i] : r_o), .root_in(adv ? root[i] : q_o),
      .tag_in(adv ? tag[i] : t_o),
      .rem_out(r_o), .root_out(q_o), .tag_out(t_o)
    );
    // A held cell recomputes from its own output; the bit already decided
    // cannot be taken twice because the remainder is below its trial.
    assign rem[i+1]  = r_o;
    assign root[i+1] = q_o;
    assign tag[i+1]  = t_o;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= tag[NCell].valid;
    if (adv) begin
      out_item.magnitude <= tag[NCell].clip ? 8'd255 : root[NCell][7:0];
      out_item.row       <= tag[NCell].row;
      out_item.column    <= tag[NCell].column;
      out_item.last      <= tag[NCell].last;
    end
  end

  // A stalled output keeps its item.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output changed");
  // Input is stalled exactly when the output is blocked.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("stall mismatch");
  // Results never carry a border position.
  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.row != 12'd0 && out_item.column != 12'd0)
    else $error("border result");

endmodule
